>>> src/lskr_pkg.sv
// shared types and operation codes for the keyed-removal lifo store
package lskr_pkg;

    typedef enum logic {
        OP_PUSH   = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef struct packed {
        logic push;
        logic remove;
        logic occupied;
        logic slot_free;
    } cell_ctrl_t;

endpackage

>>> src/lskr_cell.sv
// one storage cell of the lifo chain: holds a key, compares and shifts down
module lskr_cell
    import lskr_pkg::*;
#(
    parameter int KEY_BITS = 16
) (
    input  logic                aclk,
    input  cell_ctrl_t          ctrl,
    input  logic                found,
    input  logic [KEY_BITS-1:0] key,
    input  logic [KEY_BITS-1:0] up_key,
    input  logic                above_in,
    output logic                above_out,
    output logic [KEY_BITS-1:0] key_out
);

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic                match;

    assign match     = ctrl.remove && ctrl.occupied && (key_reg == key);
    assign above_out = above_in || match;
    assign key_out   = key_reg;

    always_comb begin
        key_next = key_reg;
        if (ctrl.push && ctrl.slot_free) begin
            key_next = key;
        end else if (ctrl.remove && found && !above_in) begin
            key_next = up_key;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule

>>> src/lifo_store_with_keyed_removal_unit.sv
// top level of the bounded lifo store with removal by key
// the result of an input transfer is registered and shown on the master side in the cycle after it
// throughput: one item per cycle while results are taken; the whole cell row compares and shifts at once
// a stalled result holds off new input until it is taken or taken in the same cycle
// reset: synchronous active-low aresetn empties the store and clears the output valid
// cell contents are not reset; only places below the count are compared against a key
module lifo_store_with_keyed_removal_unit
    import lskr_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // key
    input  logic [0:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // occupancy, zero fill
    output logic [0:0]  m_tuser    // success
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                success_reg;
    logic                success_next;
    logic [4:0]          occ_reg;
    logic [4:0]          occ_next;

    logic                s_fire;
    op_t                 op;
    logic [KEY_BITS+15:0] key_ext;
    logic [KEY_BITS-1:0] key;
    logic                not_full;
    logic                found;
    logic [CNT_W+4:0]    count_ext;

    logic [CAPACITY:0]   above;
    logic [KEY_BITS-1:0] cell_keys [CAPACITY];

    assign s_tready = !out_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign op       = op_t'(s_tuser[0]);
    assign key_ext  = {{KEY_BITS{1'b0}}, s_tdata};
    assign key      = key_ext[KEY_BITS-1:0];
    assign not_full = count_reg < CNT_W'(CAPACITY);

    assign above[CAPACITY] = 1'b0;
    assign found           = above[0];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        cell_ctrl_t          ctrl;
        logic [KEY_BITS-1:0] up_key;

        assign ctrl.push      = s_fire && (op == OP_PUSH);
        assign ctrl.remove    = s_fire && (op == OP_REMOVE);
        assign ctrl.occupied  = CNT_W'(i) < count_reg;
        assign ctrl.slot_free = CNT_W'(i) == count_reg;

        if (i == CAPACITY - 1) begin : g_top
            assign up_key = cell_keys[i];
        end else begin : g_mid
            assign up_key = cell_keys[i+1];
        end

        lskr_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .found     (found),
            .key       (key),
            .up_key    (up_key),
            .above_in  (above[i+1]),
            .above_out (above[i]),
            .key_out   (cell_keys[i])
        );
    end

    always_comb begin
        count_next     = count_reg;
        success_next   = success_reg;
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (s_fire) begin
            out_valid_next = 1'b1;
            if (op == OP_PUSH) begin
                success_next = not_full;
                if (not_full) begin
                    count_next = count_reg + CNT_W'(1);
                end
            end else begin
                success_next = found;
                if (found) begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
        end
        count_ext = {5'd0, count_next};
        occ_next  = s_fire ? count_ext[4:0] : occ_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
        success_reg <= success_next;
        occ_reg     <= occ_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {3'd0, occ_reg};
    assign m_tuser[0] = success_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("store count above capacity");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (op == OP_PUSH) && not_full |=>
            (count_reg == $past(count_reg) + CNT_W'(1)) && m_tvalid && m_tuser[0])
        else $error("push into a non-full store did not grow it");

    a_remove_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (op == OP_REMOVE) |=>
            (m_tuser[0] == (count_reg != $past(count_reg))))
        else $error("removal success disagrees with count change");

endmodule

>>> tb/tb_lifo_store_with_keyed_removal_unit.sv
// testbench for the keyed-removal lifo store: directed and random pushes and removals
module tb_lifo_store_with_keyed_removal_unit;
    import lskr_pkg::*;

    localparam int DEPTH_MAX  = 16;
    localparam int IDLE_LIMIT = 4000;

    typedef struct {
        logic       success;
        logic [4:0] occupancy;
    } outcome_t;

    class lifo_scoreboard;
        logic [15:0] stored_keys[DEPTH_MAX];
        int          depth;
        outcome_t    pending[$];
        int          mismatches;
        int          results_seen;
        int          pushes;
        int          removes;
        int          full_rejects;
        int          misses;
        int          peak;

        function new();
            depth        = 0;
            mismatches   = 0;
            results_seen = 0;
            pushes       = 0;
            removes      = 0;
            full_rejects = 0;
            misses       = 0;
            peak         = 0;
        endfunction

        // apply one accepted input transfer and queue the result it must give
        function void note_item(op_t op, logic [15:0] key);
            outcome_t o;
            int       i;
            int       hit;
            if (op == OP_PUSH) begin
                pushes++;
                if (depth >= DEPTH_MAX) begin
                    o.success = 1'b0;
                    full_rejects++;
                end else begin
                    stored_keys[depth] = key;
                    depth++;
                    o.success = 1'b1;
                end
            end else begin
                removes++;
                hit = -1;
                for (i = depth - 1; i >= 0; i--) begin
                    if (stored_keys[i] == key) begin
                        hit = i;
                        break;
                    end
                end
                if (hit < 0) begin
                    o.success = 1'b0;
                    misses++;
                end else begin
                    for (i = hit; i + 1 < depth; i++)
                        stored_keys[i] = stored_keys[i + 1];
                    depth--;
                    o.success = 1'b1;
                end
            end
            o.occupancy = 5'(depth);
            if (depth > peak)
                peak = depth;
            pending.push_back(o);
        endfunction

        function void check_result(logic success, logic [7:0] tdata);
            outcome_t o;
            results_seen++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: success %0b tdata %02h", success,
                             tdata);
                return;
            end
            o = pending.pop_front();
            if (success !== o.success || tdata !== {3'b000, o.occupancy}) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch %0d: expected %0b occupancy %0d, got %0b tdata %02h",
                             results_seen, o.success, o.occupancy, success, tdata);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;

    lifo_scoreboard sb;
    bit             tx_steady;
    bit             rx_steady;
    int             idle_cycles;
    logic [15:0]    key_pool[6] = '{16'h0000, 16'hFFFF, 16'h8001, 16'h7FFE, 16'h00FF,
                                    16'hFF00};

    lifo_store_with_keyed_removal_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(op_t op, logic [15:0] key);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tuser  <= op;
        do
            @(posedge aclk);
        while (!s_tready);
        sb.note_item(op, key);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_random(int push_pct);
        op_t         op;
        logic [15:0] key;
        int          r;
        op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_REMOVE;
        r  = $urandom_range(0, 99);
        if (op == OP_REMOVE && sb.depth > 0 && r < 60)
            key = sb.stored_keys[$urandom_range(0, sb.depth - 1)];
        else if (r < 80)
            key = key_pool[$urandom_range(0, 5)];
        else
            key = 16'($urandom());
        send_item(op, key);
    endtask

    // result side: random back-pressure
    initial begin
        int hold;
        m_tready = 1'b0;
        hold     = 0;
        forever begin
            @(negedge aclk);
            if (hold > 0 && !rx_steady) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                m_tready <= 1'b1;
                hold = rx_steady ? 0 : pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser[0], m_tdata);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int i;
        int ph;
        int push_pct;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_PUSH;
        tx_steady   = 1'b0;
        rx_steady   = 1'b0;
        sb          = new();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty store, fill to the top with duplicates, overflow, removals
        send_item(OP_REMOVE, 16'h0000);
        send_item(OP_PUSH, 16'h0000);
        send_item(OP_PUSH, 16'hFFFF);
        send_item(OP_PUSH, 16'hAAAA);
        send_item(OP_PUSH, 16'h5555);
        send_item(OP_PUSH, 16'h1234);
        send_item(OP_PUSH, 16'hC0DE);
        send_item(OP_PUSH, 16'h1234);
        for (i = 0; i < 9; i++)
            send_item(OP_PUSH, 16'(16'h0100 + i));
        send_item(OP_PUSH, 16'hFFFF);
        send_item(OP_REMOVE, 16'hBEEF);
        send_item(OP_REMOVE, 16'h1234);
        send_item(OP_REMOVE, 16'h5555);
        send_item(OP_REMOVE, 16'h0000);
        send_item(OP_REMOVE, 16'h0108);
        send_item(OP_REMOVE, 16'h1234);
        wait_drained();

        // random phases, each with its own push bias and idling pattern
        for (ph = 0; ph < 13; ph++) begin
            if (ph == 0)
                push_pct = 90;
            else if (ph == 1)
                push_pct = 10;
            else
                push_pct = $urandom_range(20, 80);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            for (i = 0; i < 100; i++)
                send_random(push_pct);
            if (ph % 4 == 3)
                wait_drained();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        wait_drained();
        repeat (4) @(posedge aclk);
        sb.mismatches += sb.pending.size();

        $display("covered %0d pushes (%0d refused when full) and %0d removals (%0d misses)",
                 sb.pushes, sb.full_rejects, sb.removes, sb.misses);
        $display("%0d results checked, peak occupancy %0d, %0d mismatches",
                 sb.results_seen, sb.peak, sb.mismatches);
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
